// File: hw/rtl/qkn_pkg.sv
// qkn_pkg: item types, register codes and reset values for the quadrature knob navigator.
// No dependencies; used by qkn_step and quadrature_knob_navigator_top.

package qkn_pkg;

	// Configuration register codes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NAV_STEPS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NAV_GAP_MS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP_MS = 2'd3;

	localparam int unsigned CFG_DATA_W = 16;

	// Register reset values
	localparam logic [7:0]  DEBOUNCE_MS_RST  = 8'd2;
	localparam logic [7:0]  NAV_STEPS_RST    = 8'd2;
	localparam logic [15:0] NAV_GAP_MS_RST   = 16'd150;
	localparam logic [15:0] CLICK_GAP_MS_RST = 16'd50;

	// One pin sample
	typedef struct packed {
		logic [31:0] now_ms;
		logic        pin_a;
		logic        pin_b;
	} in_item_t;

	// One result
	typedef struct packed {
		logic               nav_valid;
		logic signed [31:0] nav_delta;
		logic               click_valid;
		logic signed [31:0] count_now;
		logic               turn_clockwise;
	} out_item_t;

	// Configuration registers
	typedef struct packed {
		logic [7:0]  debounce_ms;
		logic [7:0]  nav_steps;
		logic [15:0] nav_gap_ms;
		logic [15:0] click_gap_ms;
	} cfg_t;

	// Decoder and navigation state
	typedef struct packed {
		logic        a_level;
		logic        b_level;
		logic [31:0] position;
		logic        direction;
		logic [31:0] last_edge_time;
		logic [31:0] ref_position;
		logic [31:0] ref_time;
	} state_t;

endpackage

// File: hw/rtl/qkn_step.sv
// qkn_step: combinational decode and navigation rule for one pin sample.
// Depends on qkn_pkg (in_item_t, cfg_t, state_t, out_item_t).

module qkn_step (
	input  qkn_pkg::in_item_t  item,
	input  qkn_pkg::cfg_t      cfg,
	input  qkn_pkg::state_t    state,
	output qkn_pkg::state_t    state_next,
	output qkn_pkg::out_item_t result
);

	logic        changed;
	logic        bounce;
	logic        edge_ok;
	logic [31:0] edge_age;
	logic [31:0] pos_new;
	logic        dir_new;
	logic [31:0] delta;
	logic [31:0] mag;
	logic [31:0] elapsed;
	logic        do_nav;
	logic        do_click;

	// Edge detect and debounce
	assign changed  = (item.pin_a != state.a_level) || (item.pin_b != state.b_level);
	assign edge_age = item.now_ms - state.last_edge_time;
	assign bounce   = edge_age < {24'd0, cfg.debounce_ms};
	assign edge_ok  = changed && !bounce;

	// Position step on an A edge: up when A differs from B
	always_comb begin
		pos_new = state.position;
		dir_new = state.direction;
		if (edge_ok && (item.pin_a != state.a_level)) begin
			if (item.pin_a != item.pin_b) begin
				pos_new = state.position + 32'd1;
				dir_new = 1'b1;
			end else begin
				pos_new = state.position - 32'd1;
				dir_new = 1'b0;
			end
		end
	end

	// Next decoder and reference state
	always_comb begin
		state_next = state;
		if (edge_ok) begin
			state_next.a_level        = item.pin_a;
			state_next.b_level        = item.pin_b;
			state_next.last_edge_time = item.now_ms;
		end
		state_next.position  = pos_new;
		state_next.direction = dir_new;
		if (do_nav || do_click) begin
			state_next.ref_position = pos_new;
			state_next.ref_time     = item.now_ms;
		end
	end

	// Navigation rule; magnitude of the most negative delta stays 2^31
	assign delta    = pos_new - state.ref_position;
	assign mag      = delta[31] ? (32'd0 - delta) : delta;
	assign elapsed  = item.now_ms - state.ref_time;
	assign do_nav   = (mag >= {24'd0, cfg.nav_steps}) && (elapsed > {16'd0, cfg.nav_gap_ms});
	assign do_click = !do_nav && (delta != 32'd0) && (elapsed > {16'd0, cfg.click_gap_ms});

	// Result item
	always_comb begin
		result.nav_valid      = do_nav;
		result.nav_delta      = do_nav ? $signed(delta) : 32'sd0;
		result.click_valid    = do_click;
		result.count_now      = $signed(pos_new);
		result.turn_clockwise = dir_new;
	end

endmodule

// File: hw/rtl/quadrature_knob_navigator_top.sv
// quadrature_knob_navigator_top: quadrature encoder decoder with debounce and navigation events.
// Depends on qkn_pkg and qkn_step.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  in      | into      | in_valid/in_stall  | in_data  (qkn_pkg::in_item_t)
//  out     | out of    | out_valid/out_stall| out_data (qkn_pkg::out_item_t)
//  cfg     | into      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while no result is stalled; a sample passes the input register,
// then one pass of compare/add logic, into the result register, where its result is valid.
// arst_n clears handshake state, decoder state and registers to their reset values.
// A stalled result holds the result register; the input register then holds too and, if it
// holds an item, in_stall rises. cfg_ready is always high; each valid write is accepted.

module quadrature_knob_navigator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  qkn_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output qkn_pkg::out_item_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qkn_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [qkn_pkg::CFG_DATA_W-1:0]      cfg_data
);

	qkn_pkg::cfg_t      cfg_q;
	qkn_pkg::state_t    state_q;
	qkn_pkg::state_t    state_next;
	qkn_pkg::in_item_t  item_s1;
	logic               valid_s1;
	qkn_pkg::out_item_t result;
	qkn_pkg::out_item_t out_data_q;
	logic               out_valid_q;
	logic               fire_s1;
	logic               in_take;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms  <= qkn_pkg::DEBOUNCE_MS_RST;
			cfg_q.nav_steps    <= qkn_pkg::NAV_STEPS_RST;
			cfg_q.nav_gap_ms   <= qkn_pkg::NAV_GAP_MS_RST;
			cfg_q.click_gap_ms <= qkn_pkg::CLICK_GAP_MS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qkn_pkg::REG_DEBOUNCE_MS:  cfg_q.debounce_ms  <= cfg_data[7:0];
				qkn_pkg::REG_NAV_STEPS:    cfg_q.nav_steps    <= cfg_data[7:0];
				qkn_pkg::REG_NAV_GAP_MS:   cfg_q.nav_gap_ms   <= cfg_data;
				qkn_pkg::REG_CLICK_GAP_MS: cfg_q.click_gap_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// Flow control
	assign fire_s1  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
	end

	// Decode and navigation logic
	qkn_step u_step (
		.item       (item_s1),
		.cfg        (cfg_q),
		.state      (state_q),
		.state_next (state_next),
		.result     (result)
	);

	// State update on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire_s1) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Checks
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q.nav_valid && out_data_q.click_valid))
		else $error("nav and click in one item");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(state_q))
		else $error("state changed without an item");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_data_q)))
		else $error("stalled result lost or changed");

endmodule
